// File: rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants for the point-in-polygon test unit
// Stream field layout, vertex and token records passed along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

    // field widths
    localparam int VINDEX_W = 4;
    localparam int COORD_W  = 16;
    localparam int VCOUNT_W = 5;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;

    // s_tdata layout, lowest bit first
    localparam int VINDEX_LSB = 0;
    localparam int X_LSB      = VINDEX_LSB + VINDEX_W;
    localparam int Y_LSB      = X_LSB + COORD_W;
    localparam int VCOUNT_LSB = Y_LSB + COORD_W;
    localparam int S_FIELDS_W = VCOUNT_LSB + VCOUNT_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = 8;

    typedef enum logic {
        MODE_VERTEX = 1'b0,
        MODE_QUERY  = 1'b1
    } pip_mode_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } pip_vertex_t;

    // query travelling down the chain
    typedef struct packed {
        logic                      valid;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic [VCOUNT_W-1:0]       cnt;
        logic                      parity;
    } pip_token_t;

    // per-cell register: query plus the products of this cell's edge
    typedef struct packed {
        logic                      valid;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic [VCOUNT_W-1:0]       cnt;
        logic                      parity;
        logic                      active;
        logic                      straddle;
        logic                      left;
        logic                      dy_pos;
        logic signed [PROD_W-1:0]  lhs;
        logic signed [PROD_W-1:0]  rhs;
    } pip_stage_t;

endpackage

`default_nettype wire

// File: rtl/pip_cell.sv
// ----------------------------------------------------------------------------
// pip_cell: one vertex slot of the crossing-number chain
// Holds vertex IDX, forms the cross products for edge (previous, own) and
// passes the query with the updated parity to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_cell import pip_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  pip_token_t          tok_in,
    input  pip_vertex_t         prev_v,
    input  logic                wr_en,
    input  logic [VINDEX_W-1:0] wr_idx,
    input  pip_vertex_t         wr_v,
    output pip_token_t          tok_out,
    output pip_vertex_t         vert_out
);

    localparam bit Writable    = IDX < (1 << VINDEX_W);
    localparam bit CanBeActive = IDX < (1 << VCOUNT_W);

    pip_vertex_t vert_reg;
    pip_stage_t  stage_reg;
    pip_stage_t  stage_next;

    logic signed [DIFF_W-1:0] d_py_ay;
    logic signed [DIFF_W-1:0] d_bx_ax;
    logic signed [DIFF_W-1:0] d_px_ax;
    logic signed [DIFF_W-1:0] d_by_ay;
    logic                     toggle;
    logic                     cross_left;

    always_ff @(posedge aclk) begin
        if (wr_en && Writable && (wr_idx == VINDEX_W'(IDX))) begin
            vert_reg <= wr_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (adv) begin
            stage_reg <= stage_next;
        end
    end

    // edge a = own vertex, b = previous vertex
    always_comb begin
        d_py_ay = $signed({tok_in.py[COORD_W-1], tok_in.py})
                - $signed({vert_reg.y[COORD_W-1], vert_reg.y});
        d_bx_ax = $signed({prev_v.x[COORD_W-1], prev_v.x})
                - $signed({vert_reg.x[COORD_W-1], vert_reg.x});
        d_px_ax = $signed({tok_in.px[COORD_W-1], tok_in.px})
                - $signed({vert_reg.x[COORD_W-1], vert_reg.x});
        d_by_ay = $signed({prev_v.y[COORD_W-1], prev_v.y})
                - $signed({vert_reg.y[COORD_W-1], vert_reg.y});

        stage_next.valid    = tok_in.valid;
        stage_next.px       = tok_in.px;
        stage_next.py       = tok_in.py;
        stage_next.cnt      = tok_in.cnt;
        stage_next.parity   = tok_in.parity;
        stage_next.active   = CanBeActive && (tok_in.cnt > VCOUNT_W'(IDX));
        stage_next.straddle = ((vert_reg.y < tok_in.py) && (prev_v.y >= tok_in.py))
                           || ((prev_v.y < tok_in.py) && (vert_reg.y >= tok_in.py));
        stage_next.left     = (vert_reg.x <= tok_in.px) || (prev_v.x <= tok_in.px);
        stage_next.dy_pos   = prev_v.y > vert_reg.y;
        stage_next.lhs      = d_py_ay * d_bx_ax;
        stage_next.rhs      = d_px_ax * d_by_ay;
    end

    // exact test of crossing x < px, sign of dy folded into the compare
    always_comb begin
        cross_left = stage_reg.dy_pos ? (stage_reg.lhs < stage_reg.rhs)
                                      : (stage_reg.lhs > stage_reg.rhs);
        toggle     = stage_reg.active && stage_reg.straddle && stage_reg.left && cross_left;

        tok_out.valid  = stage_reg.valid;
        tok_out.px     = stage_reg.px;
        tok_out.py     = stage_reg.py;
        tok_out.cnt    = stage_reg.cnt;
        tok_out.parity = stage_reg.parity ^ toggle;
    end

    assign vert_out = vert_reg;

endmodule

`default_nettype wire

// File: rtl/point_in_polygon_test_unit.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test_unit: even-odd polygon hit test
// Vertex transactions fill a chain of cells; a query walks the chain, one
// cell per cycle unless stalled, toggling a parity bit at each edge crossed left of the point.
//
//   Channel  Dir  tdata fields (low bit up)                         tuser
//   s_       in   vertex_index[3:0] coord_x[19:4] coord_y[35:20]    mode
//                 vertex_count[40:36], zero pad to 48
//   m_       out  inside_res[0], zero pad to 8                      -
//
// A vertex transaction is written when accepted; s_tready stays high.
// A query holds s_tready low from acceptance until its result is valid:
// it passes the input register, then each cell's register in turn, and
// finally the output register.
// The whole chain walks every cell; cells beyond vertex_count pass parity.
// A result held on m_ (m_tready low) stalls every cell once a result reaches the last.
// Reset is synchronous; the vertex store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_polygon_test_unit import pip_pkg::*; #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // vertex_index, coord_x, coord_y, vertex_count
    input  logic [S_TDATA_W-1:0] s_tdata,
    // mode
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // inside_res
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int IdxW   = $clog2(MAX_VERTICES);
    localparam int SelW   = (IdxW > VCOUNT_W) ? IdxW : VCOUNT_W;
    localparam int CntCap = (MAX_VERTICES < (1 << VCOUNT_W) - 1)
                          ? MAX_VERTICES : (1 << VCOUNT_W) - 1;

    pip_token_t  tok [MAX_VERTICES+1];
    pip_vertex_t vert [MAX_VERTICES];

    pip_token_t  q_reg, q_next;
    pip_vertex_t wrap_reg;
    logic        busy_reg, busy_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic        inside_reg, inside_next;

    logic                in_acc;
    logic                q_acc;
    logic                v_wr;
    logic                adv;
    logic                done;
    logic [VCOUNT_W-1:0] cnt_in;
    logic [VCOUNT_W-1:0] cnt_eff;
    logic [SelW-1:0]     sel_wide;
    logic [IdxW-1:0]     wrap_sel;
    pip_vertex_t         in_v;

    assign s_tready = !busy_reg;
    assign in_acc   = s_tvalid && s_tready;
    assign q_acc    = in_acc && (pip_mode_t'(s_tuser) == MODE_QUERY);
    assign v_wr     = in_acc && (pip_mode_t'(s_tuser) == MODE_VERTEX);

    assign in_v.x = s_tdata[X_LSB +: COORD_W];
    assign in_v.y = s_tdata[Y_LSB +: COORD_W];
    assign cnt_in = s_tdata[VCOUNT_LSB +: VCOUNT_W];

    // the last cell's result stalls while the output register is held
    assign done = tok[MAX_VERTICES].valid;
    assign adv  = !(done && m_tvalid_reg && !m_tready);

    always_comb begin
        cnt_eff  = (cnt_in > VCOUNT_W'(CntCap)) ? VCOUNT_W'(CntCap) : cnt_in;
        sel_wide = (cnt_eff == '0) ? '0 : (SelW'(cnt_eff) - SelW'(1));
        wrap_sel = sel_wide[IdxW-1:0];

        q_next = q_reg;
        if (q_acc) begin
            q_next.valid  = 1'b1;
            q_next.px     = in_v.x;
            q_next.py     = in_v.y;
            q_next.cnt    = cnt_eff;
            q_next.parity = 1'b0;
        end else if (adv) begin
            q_next.valid = 1'b0;
        end

        busy_next = busy_reg;
        if (q_acc) begin
            busy_next = 1'b1;
        end else if (done && adv) begin
            busy_next = 1'b0;
        end

        m_tvalid_next = m_tvalid_reg;
        inside_next   = inside_reg;
        if (done && adv) begin
            m_tvalid_next = 1'b1;
            inside_next   = tok[MAX_VERTICES].parity;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.valid  <= 1'b0;
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            q_reg        <= q_next;
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // first cell's edge closes the polygon from vertex count-1
    always_ff @(posedge aclk) begin
        inside_reg <= inside_next;
        if (q_acc) begin
            wrap_reg <= vert[wrap_sel];
        end
    end

    assign tok[0] = q_reg;

    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
        pip_vertex_t prev_v;
        if (k == 0) begin : g_first
            assign prev_v = wrap_reg;
        end else begin : g_rest
            assign prev_v = vert[k-1];
        end
        pip_cell #(
            .IDX (k)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .tok_in   (tok[k]),
            .prev_v   (prev_v),
            .wr_en    (v_wr),
            .wr_idx   (s_tdata[VINDEX_LSB +: VINDEX_W]),
            .wr_v     (in_v),
            .tok_out  (tok[k+1]),
            .vert_out (vert[k])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(inside_reg);

endmodule

`default_nettype wire

// File: rtl/pip_checker.sv
// ----------------------------------------------------------------------------
// pip_checker: port-level checks for point_in_polygon_test_unit
// Watches both stream channels; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_checker import pip_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // held result keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a query occupies the unit until its result is registered
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == MODE_QUERY) |=> !s_tready)
        else $error("unit ready one cycle after query");

    a_vertex_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == MODE_VERTEX) |=> s_tready)
        else $error("vertex transaction blocked the input");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:1] == '0))
        else $error("result padding not zero");

endmodule

bind point_in_polygon_test_unit pip_checker u_pip_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for point_in_polygon_test_unit
// Drives vertex and query transactions on the s_ stream and checks every
// inside/outside result on m_ against an even-odd crossing predictor kept
// in the bench. A short directed table comes first. Random polygon bursts
// and noise follow, under four phases of source idling and sink stalling.
// ----------------------------------------------------------------------------
module tb import pip_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS    = 16;
    localparam int PHASE_ITEMS  = 470;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        pip_mode_t           mode;
        logic [VINDEX_W-1:0] idx;
        logic signed [15:0]  x;
        logic signed [15:0]  y;
        logic [VCOUNT_W-1:0] cnt;
        logic                fixed;   // expected result typed in below
        logic                hit;
    } stim_row_t;

    localparam int NUM_DIRECTED = 26;

    // Full-screen square in slots 0..3; slots 4..15 repeat the last corner,
    // giving zero-length edges so a full count still sees the same square.
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{MODE_QUERY,  4'd0,  16'sd0,   16'sd0,   5'd0,  1'b1, 1'b0}, // empty polygon
        '{MODE_VERTEX, 4'd0,  16'h8000, 16'h8000, 5'd0,  1'b0, 1'b0},
        '{MODE_VERTEX, 4'd1,  16'h7fff, 16'h8000, 5'd0,  1'b0, 1'b0},
        '{MODE_VERTEX, 4'd2,  16'h7fff, 16'h7fff, 5'd0,  1'b0, 1'b0},
        '{MODE_VERTEX, 4'd3,  16'h8000, 16'h7fff, 5'd0,  1'b0, 1'b0},
        '{MODE_QUERY,  4'd0,  16'sd0,   16'sd0,   5'd4,  1'b1, 1'b1},
        '{MODE_QUERY,  4'd0,  16'h8000, 16'sd0,   5'd4,  1'b0, 1'b0}, // on left edge
        '{MODE_QUERY,  4'd0,  16'sd0,   16'h8000, 5'd4,  1'b0, 1'b0}, // on horizontal edge
        '{MODE_QUERY,  4'd15, 16'h7fff, 16'h7fff, 5'd4,  1'b0, 1'b0}, // corner
        '{MODE_QUERY,  4'd0,  16'sd0,   16'sd0,   5'd1,  1'b1, 1'b0}, // single vertex
        '{MODE_QUERY,  4'd0,  16'sd0,   16'sd0,   5'd2,  1'b0, 1'b0}, // two vertices
        '{MODE_QUERY,  4'd0,  16'sd0,   16'sd0,   5'd3,  1'b0, 1'b0}, // point on diagonal
        '{MODE_VERTEX, 4'd4,  16'h8000, 16'h7fff, 5'd31, 1'b0, 1'b0},
        '{MODE_VERTEX, 4'd5,  16'h8000, 16'h7fff, 5'd0,  1'b0, 1'b0},
        '{MODE_VERTEX, 4'd6,  16'h8000, 16'h7fff, 5'd0,  1'b0, 1'b0},
        '{MODE_VERTEX, 4'd7,  16'h8000, 16'h7fff, 5'd0,  1'b0, 1'b0},
        '{MODE_VERTEX, 4'd8,  16'h8000, 16'h7fff, 5'd0,  1'b0, 1'b0},
        '{MODE_VERTEX, 4'd9,  16'h8000, 16'h7fff, 5'd0,  1'b0, 1'b0},
        '{MODE_VERTEX, 4'd10, 16'h8000, 16'h7fff, 5'd0,  1'b0, 1'b0},
        '{MODE_VERTEX, 4'd11, 16'h8000, 16'h7fff, 5'd0,  1'b0, 1'b0},
        '{MODE_VERTEX, 4'd12, 16'h8000, 16'h7fff, 5'd0,  1'b0, 1'b0},
        '{MODE_VERTEX, 4'd13, 16'h8000, 16'h7fff, 5'd0,  1'b0, 1'b0},
        '{MODE_VERTEX, 4'd14, 16'h8000, 16'h7fff, 5'd0,  1'b0, 1'b0},
        '{MODE_VERTEX, 4'd15, 16'h8000, 16'h7fff, 5'd0,  1'b0, 1'b0},
        '{MODE_QUERY,  4'd0,  16'sd0,   16'sd0,   5'd16, 1'b1, 1'b1},
        '{MODE_QUERY,  4'd0,  16'sd100, -16'sd100, 5'd31, 1'b1, 1'b1} // count clamps to 16
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // typed expectation travels with the transaction it belongs to
    logic                 row_fixed = 1'b0;
    logic                 row_inside = 1'b0;

    logic signed [15:0]   vert_x [NUM_SLOTS];
    logic signed [15:0]   vert_y [NUM_SLOTS];
    bit                   pending_inside [$];

    int                   mismatches = 0;
    int                   idle_cycles = 0;
    int                   items_sent = 0;
    int                   idle_pct = 0;
    int                   stall_pct = 0;
    bit                   hold_req = 1'b0;

    point_in_polygon_test_unit #(
        .MAX_VERTICES(NUM_SLOTS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Edge (a, b) flips parity when it straddles row py and crosses it
    // strictly left of px; exact compare via cross-multiplication.
    function automatic bit crosses_left(longint ax, longint ay, longint bx, longint by,
                                        longint px, longint py);
        longint dy;
        longint lhs;
        longint rhs;
        if (!((ay < py && by >= py) || (by < py && ay >= py)))
            return 1'b0;
        if (!(ax <= px || bx <= px))
            return 1'b0;
        dy  = by - ay;
        lhs = (py - ay) * (bx - ax);
        rhs = (px - ax) * dy;
        return (dy > 0) ? (lhs < rhs) : (lhs > rhs);
    endfunction

    function automatic bit inside_by_parity(logic signed [15:0] px, logic signed [15:0] py,
                                            logic [VCOUNT_W-1:0] cnt);
        int n;
        int prev;
        bit parity;
        n = (cnt > NUM_SLOTS) ? NUM_SLOTS : int'(cnt);
        parity = 1'b0;
        prev = n - 1;
        for (int i = 0; i < n; i++) begin
            if (crosses_left(vert_x[i], vert_y[i], vert_x[prev], vert_y[prev], px, py))
                parity = ~parity;
            prev = i;
        end
        return parity;
    endfunction

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic logic signed [15:0] clamp16(int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    task automatic note_mismatch(string what, logic [M_TDATA_W-1:0] exp_data,
                                 logic [M_TDATA_W-1:0] act_data);
        if (mismatches < REPORT_MAX)
            $display("%0t: %s: expected m_tdata %h, got %h", $realtime, what, exp_data,
                     act_data);
        mismatches++;
    endtask

    // Monitor: checks results, predicts accepted queries, runs the watchdog.
    always @(posedge aclk) begin : monitor
        logic                moved;
        logic [M_TDATA_W-1:0] want;
        bit                  exp_hit;
        pip_mode_t           mode;
        logic [VINDEX_W-1:0] idx;
        logic signed [15:0]  px;
        logic signed [15:0]  py;
        logic [VCOUNT_W-1:0] cnt;
        if (aresetn) begin
            moved = 1'b0;
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                if (pending_inside.size() == 0) begin
                    note_mismatch("unexpected result", '0, m_tdata);
                end else begin
                    want = {{(M_TDATA_W-1){1'b0}}, pending_inside.pop_front()};
                    if (m_tdata !== want)
                        note_mismatch("inside_res", want, m_tdata);
                end
            end
            if (s_tvalid && s_tready) begin
                moved = 1'b1;
                mode = pip_mode_t'(s_tuser);
                idx  = s_tdata[VINDEX_LSB +: VINDEX_W];
                px   = s_tdata[X_LSB +: COORD_W];
                py   = s_tdata[Y_LSB +: COORD_W];
                cnt  = s_tdata[VCOUNT_LSB +: VCOUNT_W];
                if (mode == MODE_VERTEX) begin
                    vert_x[idx] = px;
                    vert_y[idx] = py;
                end else begin
                    exp_hit = row_fixed ? row_inside : inside_by_parity(px, py, cnt);
                    pending_inside.push_back(exp_hit);
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Sink: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= (int'($urandom_range(99)) >= stall_pct);
        end
    end

    task automatic send_item(pip_mode_t mode, logic [VINDEX_W-1:0] idx,
                             logic signed [15:0] x, logic signed [15:0] y,
                             logic [VCOUNT_W-1:0] cnt, logic fixed, logic exp_hit);
        logic [S_TDATA_W-1:0] word;
        while (idle_pct != 0 && int'($urandom_range(99)) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        word = '0;
        word[VINDEX_LSB +: VINDEX_W] = idx;
        word[X_LSB +: COORD_W]       = x;
        word[Y_LSB +: COORD_W]       = y;
        word[VCOUNT_LSB +: VCOUNT_W] = cnt;
        s_tvalid   <= 1'b1;
        s_tuser    <= mode;
        s_tdata    <= word;
        row_fixed  <= fixed;
        row_inside <= exp_hit;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // A polygon written to slots 0..n-1, then queries aimed at it: on
    // vertices, on rows through vertices, and in or just around its bounding box.
    task automatic polygon_burst();
        int n;
        int span;
        int cx;
        int cy;
        int minx;
        int maxx;
        int miny;
        int maxy;
        int k;
        int px;
        int py;
        int xs [NUM_SLOTS];
        int ys [NUM_SLOTS];
        logic [VCOUNT_W-1:0] cnt;
        n = ($urandom_range(9) == 0) ? int'($urandom_range(9, NUM_SLOTS))
                                     : int'($urandom_range(3, 8));
        case ($urandom_range(2))
            0: span = 6;
            1: span = 1000;
            default: span = 32767;
        endcase
        cx = (span == 32767) ? 0 : rand_between(-30000, 30000);
        cy = (span == 32767) ? 0 : rand_between(-30000, 30000);
        minx = 32767;
        maxx = -32768;
        miny = 32767;
        maxy = -32768;
        for (int i = 0; i < n; i++) begin
            xs[i] = clamp16(cx + rand_between(-span, span));
            ys[i] = clamp16(cy + rand_between(-span, span));
            if (xs[i] < minx) minx = xs[i];
            if (xs[i] > maxx) maxx = xs[i];
            if (ys[i] < miny) miny = ys[i];
            if (ys[i] > maxy) maxy = ys[i];
            send_item(MODE_VERTEX, i[VINDEX_W-1:0], 16'(xs[i]), 16'(ys[i]),
                      VCOUNT_W'($urandom_range(31)), 1'b0, 1'b0);
        end
        repeat ($urandom_range(2, 8)) begin
            k = int'($urandom_range(n - 1));
            px = rand_between(minx - 2, maxx + 2);
            py = rand_between(miny - 2, maxy + 2);
            case ($urandom_range(3))
                0: begin
                    px = xs[k];
                    py = ys[k];
                end
                1: py = ys[k];
                default: ;
            endcase
            cnt = ($urandom_range(4) == 0) ? VCOUNT_W'($urandom_range(31))
                                           : n[VCOUNT_W-1:0];
            send_item(MODE_QUERY, VINDEX_W'($urandom_range(15)), clamp16(px), clamp16(py),
                      cnt, 1'b0, 1'b0);
        end
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (pending_inside.size() != 0);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].mode, directed_rows[i].idx, directed_rows[i].x,
                      directed_rows[i].y, directed_rows[i].cnt, directed_rows[i].fixed,
                      directed_rows[i].hit);
        wait_results_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct = 0;
                    stall_pct = 0;
                    hold_req = 1'b1;   // sink holds off while the source keeps offering
                end
                1: begin
                    idle_pct = 46;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct = 46;
                end
                default: begin
                    idle_pct = 34;
                    stall_pct = 34;
                end
            endcase
            items_sent = 0;
            while (items_sent < PHASE_ITEMS) begin
                if ($urandom_range(99) < 15) begin
                    // noise: full-range vertex or query
                    send_item(pip_mode_t'($urandom_range(1)), VINDEX_W'($urandom_range(15)),
                              16'($urandom), 16'($urandom), VCOUNT_W'($urandom_range(31)),
                              1'b0, 1'b0);
                end else begin
                    polygon_burst();
                end
            end
            wait_results_drained();
        end

        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_inside.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
